/* rtl/infix_expression_evaluator_top_assert.svh */
// Assertion macros for the infix expression evaluator.
`ifndef INFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define IEE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IEE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IEE_ASSERT_IMP(label, clk, rst, ante, cons)
`define IEE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/iee_pkg.sv */
// Shared types, codes and the command and status structs for the infix expression evaluator.
package iee_pkg;
  localparam int VALUE_DEPTH = 16;
  localparam int OPERATOR_DEPTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int VAW = $clog2(VALUE_DEPTH);
  localparam int OAW = $clog2(OPERATOR_DEPTH);
  localparam int VCW = $clog2(VALUE_DEPTH + 1);
  localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
  localparam int DCW = $clog2(DATA_WIDTH + 1);

  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3, OP_DIV = 3'd4,
    OP_LPAR = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DIV0 = 3'd1, ST_MALFORMED = 3'd2, ST_OVERFLOW = 3'd3,
    ST_BADCHAR = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FLUSH, S_LOOP, S_POP_B, S_POP_A, S_EXEC, S_DIV_WAIT,
    S_PUSH, S_PUSHOP, S_FINISH, S_OUT
  } state_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       load_char;
    logic       digit;
    logic       push_num;
    logic       push_op;
    op_t        push_code;
    logic       pop_op;
    logic       pop_b;
    logic       pop_a;
    logic       exec;
    logic       div_start;
    logic       push_res;
    logic       set_err;
    status_t    err;
    logic       load_out;
    logic       clear;
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic        in_number;
    logic        err_set;
    logic        vfull;
    logic        ofull;
    logic        oempty;
    logic [VCW-1:0] vcount;
    op_t         top_op;
    op_t         cur_op;
    logic        b_zero;
    logic        div_done;
  } sts_t;

  function automatic logic [1:0] prec(op_t op);
    case (op)
      OP_ADD, OP_SUB: prec = 2'd1;
      OP_MUL, OP_DIV: prec = 2'd2;
      default:        prec = 2'd0;
    endcase
  endfunction
endpackage

/* rtl/infix_expression_evaluator_top.sv */
// Top level of the infix expression evaluator.
//  channel | direction | contents
//  s_axis  | in        | tdata[7:0] char_code, tlast end_of_expr
//  m_axis  | out       | tdata[31:0] value, tuser[2:0] status
// A character is worked by the controller, with a reduction for each operator
// it triggers; a division runs in the
// shift-subtract divider. The last character also drains the stacks, one
// reduction at a time. rst is synchronous and clears the stack counters, the accumulator and the
// error. The input stalls while a character is worked or a result waits;
// the result holds until taken.
module infix_expression_evaluator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import iee_pkg::*;
  cmd_t    cmd;
  sts_t    sts;
  status_t st;

  iee_control u_ctl (
    .clk(clk), .rst(rst), .in_fire(s_axis_tvalid && s_axis_tready),
    .out_taken(m_axis_tvalid && m_axis_tready), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .cmd(cmd), .sts(sts)
  );

  iee_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_char(s_axis_tdata),
    .in_last(s_axis_tlast), .out_value(m_axis_tdata), .out_status(st)
  );

  assign m_axis_tuser = st;
endmodule

/* rtl/iee_divider.sv */
// Radix-2 restoring divider for signed operands, truncating toward zero.
module iee_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [iee_pkg::DATA_WIDTH-1:0] a,
  input  logic [iee_pkg::DATA_WIDTH-1:0] b,
  output logic                           done,
  output logic [iee_pkg::DATA_WIDTH-1:0] q
);
  import iee_pkg::*;
  logic [DATA_WIDTH-1:0] quo, div;
  logic [DATA_WIDTH:0]   rem;
  logic [DCW-1:0]        cnt;
  logic                  busy, neg;
  logic [DATA_WIDTH:0]   trial;

  assign trial = {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]} - {1'b0, div};
  assign q = neg ? (~quo + 1'b1) : quo;

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCW'(DATA_WIDTH);
        rem  <= '0;
        quo  <= a[DATA_WIDTH-1] ? ~a + 1'b1 : a;
        div  <= b[DATA_WIDTH-1] ? ~b + 1'b1 : b;
        neg  <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      end else if (busy) begin
        if (!trial[DATA_WIDTH]) begin
          rem <= trial;
          quo <= {quo[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem <= {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
          quo <= {quo[DATA_WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/iee_datapath.sv */
// Datapath: stacks, number accumulator, arithmetic unit and result register.
module iee_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  iee_pkg::cmd_t                  cmd,
  output iee_pkg::sts_t                  sts,
  input  logic [7:0]                     in_char,
  input  logic                           in_last,
  output logic [iee_pkg::DATA_WIDTH-1:0] out_value,
  output iee_pkg::status_t               out_status
);
  import iee_pkg::*;
  logic [DATA_WIDTH-1:0] vstack [VALUE_DEPTH];
  op_t                   ostack [OPERATOR_DEPTH];
  logic [VCW-1:0]        vcount;
  logic [OCW-1:0]        ocount;
  logic [DATA_WIDTH-1:0] accum, opa, opb, res, vtop;
  logic                  in_number, last;
  logic [7:0]            ch;
  status_t               err;
  op_t                   cur;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] quo;

  iee_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .a(opa), .b(opb),
    .done(div_done), .q(quo)
  );

  assign vtop = vstack[VAW'(vcount - 1'b1)];

  // Status to the controller.
  always_comb begin
    sts.ch        = ch;
    sts.last      = last;
    sts.in_number = in_number;
    sts.err_set   = (err != ST_OK);
    sts.vfull     = (vcount == VCW'(VALUE_DEPTH));
    sts.ofull     = (ocount == OCW'(OPERATOR_DEPTH));
    sts.oempty    = (ocount == '0);
    sts.vcount    = vcount;
    sts.top_op    = ostack[OAW'(ocount - 1'b1)];
    sts.cur_op    = cur;
    sts.b_zero    = (opb == '0);
    sts.div_done  = div_done;
  end

  // Stack storage, written in place, with the popped operands, the character register and the result.
  always_ff @(posedge clk) begin
    if (cmd.push_num) vstack[VAW'(vcount)] <= accum;
    if (cmd.push_res) vstack[VAW'(vcount)] <= res;
    if (cmd.push_op)  ostack[OAW'(ocount)] <= cmd.push_code;
    if (cmd.pop_op)   cur <= ostack[OAW'(ocount - 1'b1)];
    if (cmd.pop_b)    opb <= vtop;
    if (cmd.pop_a)    opa <= vtop;
    if (cmd.load_char) begin
      ch   <= in_char;
      last <= in_last;
    end
    // Arithmetic result for the popped operator.
    if (cmd.exec) begin
      case (cur)
        OP_ADD:  res <= opa + opb;
        OP_SUB:  res <= opa - opb;
        OP_MUL:  res <= opa * opb;
        default: res <= res;
      endcase
    end
    if (div_done) res <= quo;
  end

  // Counters, accumulator and sticky error.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vcount    <= '0;
      ocount    <= '0;
      accum     <= '0;
      in_number <= 1'b0;
      err       <= ST_OK;
    end else begin
      if (cmd.digit) begin
        in_number <= 1'b1;
        accum <= (in_number ? (accum << 3) + (accum << 1) : '0)
                 + DATA_WIDTH'(ch - 8'h30);
      end
      if (cmd.push_num) begin
        in_number <= 1'b0;
        accum     <= '0;
      end
      if (cmd.push_num || cmd.push_res) vcount <= vcount + 1'b1;
      if (cmd.pop_b || cmd.pop_a)       vcount <= vcount - 1'b1;
      if (cmd.push_op) ocount <= ocount + 1'b1;
      if (cmd.pop_op)  ocount <= ocount - 1'b1;
      if (cmd.set_err && err == ST_OK) err <= cmd.err;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= (err == ST_OK && vcount != VCW'(1)) ? ST_MALFORMED : err;
      out_value  <= (err == ST_OK && vcount == VCW'(1)) ? vstack[0] : '0;
    end
  end
endmodule

/* rtl/iee_control.sv */
// Controller state machine sequencing characters and reductions.
module iee_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_taken,
  output logic           in_ready,
  output logic           out_valid,
  output iee_pkg::cmd_t  cmd,
  input  iee_pkg::sts_t  sts
);
  import iee_pkg::*;
  `include "infix_expression_evaluator_top_assert.svh"
  state_t state, state_next;
  op_t    pend, pend_next;
  logic   closing, closing_next;
  logic   is_digit;
  op_t    ch_op;

  assign is_digit = (sts.ch >= 8'h30) && (sts.ch <= 8'h39);

  always_comb begin
    case (sts.ch)
      8'h2B:   ch_op = OP_ADD;
      8'h2D:   ch_op = OP_SUB;
      8'h2A:   ch_op = OP_MUL;
      8'h2F:   ch_op = OP_DIV;
      default: ch_op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pend    <= OP_NONE;
      closing <= 1'b0;
    end else begin
      state   <= state_next;
      pend    <= pend_next;
      closing <= closing_next;
    end
  end

  // Next state. The loop state decides whether another reduction runs.
  always_comb begin
    state_next   = state;
    pend_next    = pend;
    closing_next = closing;
    case (state)
      S_IDLE: if (in_fire) state_next = S_DISPATCH;
      S_DISPATCH: begin
        closing_next = 1'b0;
        if (sts.err_set) state_next = S_FINISH;
        else if (is_digit) state_next = S_FINISH;
        else if (sts.in_number) state_next = S_FLUSH;
        else if (sts.ch == 8'h20) state_next = S_FINISH;
        else if (sts.ch == 8'h28) state_next = S_PUSHOP;
        else if (sts.ch == 8'h29) begin
          closing_next = 1'b1;
          state_next = S_LOOP;
        end else if (ch_op != OP_NONE) begin
          pend_next = ch_op;
          state_next = S_LOOP;
        end else state_next = S_FINISH;
      end
      S_FLUSH: state_next = sts.vfull ? S_FINISH : S_DISPATCH;
      S_LOOP: begin
        if (sts.err_set) state_next = S_FINISH;
        else if (closing) begin
          if (sts.oempty || sts.top_op == OP_LPAR) state_next = S_FINISH;
          else state_next = S_POP_B;
        end else if (!sts.oempty && prec(sts.top_op) >= prec(pend))
          state_next = S_POP_B;
        else state_next = S_PUSHOP;
      end
      S_POP_B: state_next =
        (sts.cur_op == OP_LPAR || sts.vcount < VCW'(2)) ? S_LOOP : S_POP_A;
      S_POP_A: state_next = S_EXEC;
      S_EXEC: begin
        if (sts.cur_op == OP_DIV)
          state_next = sts.b_zero ? S_LOOP : S_DIV_WAIT;
        else state_next = S_PUSH;
      end
      S_DIV_WAIT: if (sts.div_done) state_next = S_PUSH;
      S_PUSH:   state_next = S_LOOP;
      S_PUSHOP: state_next = S_FINISH;
      S_FINISH: begin
        // The character is done, so the pending operator and close mark end here.
        pend_next    = OP_NONE;
        closing_next = 1'b0;
        if (!sts.last) state_next = S_IDLE;
        else if (!sts.err_set && sts.in_number) state_next = S_FLUSH;
        else if (!sts.err_set && !sts.oempty) state_next = S_POP_B;
        else state_next = S_OUT;
      end
      S_OUT: if (out_taken) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // After flushing on the last item, return to the final drain.
    if (state == S_FLUSH && sts.last && (is_digit || sts.ch == 8'h20 || sts.err_set))
      state_next = S_FINISH;
    // Reductions at the end return to the drain instead of the loop.
    if (state_next == S_LOOP && !closing_next && pend_next == OP_NONE)
      state_next = S_FINISH;
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: cmd.load_char = in_fire;
      S_DISPATCH: begin
        if (!sts.err_set) begin
          if (is_digit) cmd.digit = 1'b1;
          else if (!sts.in_number && sts.ch != 8'h20 && sts.ch != 8'h28 &&
                   sts.ch != 8'h29 && ch_op == OP_NONE) begin
            cmd.set_err = 1'b1;
            cmd.err = ST_BADCHAR;
          end
        end
      end
      S_FLUSH: begin
        if (sts.vfull) begin
          cmd.set_err = 1'b1;
          cmd.err = ST_OVERFLOW;
        end else cmd.push_num = 1'b1;
      end
      S_LOOP: begin
        if (!sts.err_set && closing) begin
          if (sts.oempty) begin
            cmd.set_err = 1'b1;
            cmd.err = ST_MALFORMED;
          end else if (sts.top_op == OP_LPAR) cmd.pop_op = 1'b1;
          else cmd.pop_op = 1'b1;
        end else if (!sts.err_set && !sts.oempty && prec(sts.top_op) >= prec(pend))
          cmd.pop_op = 1'b1;
      end
      S_POP_B: begin
        if (sts.cur_op == OP_LPAR || sts.vcount < VCW'(2)) begin
          cmd.set_err = 1'b1;
          cmd.err = ST_MALFORMED;
        end else cmd.pop_b = 1'b1;
      end
      S_POP_A: cmd.pop_a = 1'b1;
      S_EXEC: begin
        if (sts.cur_op == OP_DIV) begin
          if (sts.b_zero) begin
            cmd.set_err = 1'b1;
            cmd.err = ST_DIV0;
          end else cmd.div_start = 1'b1;
        end else cmd.exec = 1'b1;
      end
      S_PUSH: begin
        if (sts.vfull) begin
          cmd.set_err = 1'b1;
          cmd.err = ST_OVERFLOW;
        end else cmd.push_res = 1'b1;
      end
      S_PUSHOP: begin
        if (sts.ofull) begin
          cmd.set_err = 1'b1;
          cmd.err = ST_OVERFLOW;
        end else if (!sts.err_set) begin
          cmd.push_op = 1'b1;
          cmd.push_code = (sts.ch == 8'h28) ? OP_LPAR : pend;
        end
      end
      S_FINISH: begin
        if (sts.last && (sts.err_set || (!sts.in_number && sts.oempty)))
          cmd.load_out = 1'b1;
        if (sts.last && !sts.err_set && !sts.in_number && !sts.oempty)
          cmd.pop_op = 1'b1;
      end
      S_OUT: cmd.clear = out_taken;
      default: ;
    endcase
  end

  `IEE_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, !out_valid)
  `IEE_ASSERT_NEXT(a_load_out, clk, rst, cmd.load_out, state == S_OUT)
  `IEE_ASSERT_IMP(a_div_in_exec, clk, rst, cmd.div_start, sts.cur_op == OP_DIV)
endmodule
